// ===== design/jdkf_pkg.sv =====
// Shared types, codes and constants of the JSON direct key finder.
package jdkf_pkg;

    localparam int DEPTH_BITS_DEFAULT    = 8;
    localparam int OFFSET_BITS_DEFAULT   = 16;
    localparam int MAX_KEY_BYTES_DEFAULT = 16;

    localparam int KEY_WORD_BITS  = 64;
    localparam int KEY_LEN_BITS   = 5;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [7:0] CHAR_OBJ_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_OBJ_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_ARR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_ARR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_SEARCH    = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        MODE_IDLE        = 7'b0000001,
        MODE_SCAN        = 7'b0000010,
        MODE_STR         = 7'b0000100,
        MODE_KEY         = 7'b0001000,
        MODE_AFTER_KEY   = 7'b0010000,
        MODE_AFTER_COLON = 7'b0100000,
        MODE_DONE        = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] value_offset;
        logic [7:0]  value_byte;
    } result_t;

endpackage

// ===== design/jdkf_cfg_regs.sv =====
// Configuration registers holding the wanted key and its length.
module jdkf_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [jdkf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [jdkf_pkg::KEY_WORD_BITS-1:0]   cfg_data,
    output logic [2*jdkf_pkg::KEY_WORD_BITS-1:0] key_bytes,
    output logic [jdkf_pkg::KEY_LEN_BITS-1:0]    key_length
);

    logic [jdkf_pkg::KEY_WORD_BITS-1:0] key_low_reg;
    logic [jdkf_pkg::KEY_WORD_BITS-1:0] key_high_reg;
    logic [jdkf_pkg::KEY_LEN_BITS-1:0]  key_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (jdkf_pkg::cfg_index_t'(cfg_index))
                jdkf_pkg::CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                jdkf_pkg::CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                jdkf_pkg::CFG_KEY_LENGTH:
                    key_length_reg <= cfg_data[jdkf_pkg::KEY_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign key_bytes  = {key_high_reg, key_low_reg};
    assign key_length = key_length_reg;

endmodule

// ===== design/jdkf_scan_core.sv =====
// Scan state registers and the per-byte next-state and result logic.
module jdkf_scan_core
#(
    parameter int DEPTH_BITS    = jdkf_pkg::DEPTH_BITS_DEFAULT,
    parameter int OFFSET_BITS   = jdkf_pkg::OFFSET_BITS_DEFAULT,
    parameter int MAX_KEY_BYTES = jdkf_pkg::MAX_KEY_BYTES_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step_en,
    input  logic [7:0]                           data_byte,
    input  logic                                 start_flag,
    input  logic                                 end_flag,
    input  logic [2*jdkf_pkg::KEY_WORD_BITS-1:0] key_bytes,
    input  logic [jdkf_pkg::KEY_LEN_BITS-1:0]    key_length,
    output jdkf_pkg::result_t                    result
);

    localparam logic [jdkf_pkg::KEY_LEN_BITS-1:0] KEY_LIMIT =
        jdkf_pkg::KEY_LEN_BITS'(MAX_KEY_BYTES);

    jdkf_pkg::mode_t                  mode_reg, mode_next;
    logic [DEPTH_BITS-1:0]            brace_level_reg, brace_level_next;
    logic [DEPTH_BITS-1:0]            bracket_level_reg, bracket_level_next;
    logic                             escape_reg, escape_next;
    logic [jdkf_pkg::KEY_LEN_BITS-1:0] key_index_reg, key_index_next;
    logic                             key_match_reg, key_match_next;
    logic [OFFSET_BITS-1:0]           offset_reg, offset_next;
    jdkf_pkg::status_t                final_reg, final_next;

    logic       do_scan;
    logic       do_key;
    logic       is_ws;
    logic [7:0] wanted;

    assign is_ws  = data_byte inside {jdkf_pkg::CHAR_SPACE,
                                      [jdkf_pkg::CHAR_TAB:jdkf_pkg::CHAR_CR]};
    assign wanted = key_bytes[8*key_index_reg[3:0] +: 8];

    always_comb
    begin
        mode_next          = mode_reg;
        brace_level_next   = brace_level_reg;
        bracket_level_next = bracket_level_reg;
        escape_next        = escape_reg;
        key_index_next     = key_index_reg;
        key_match_next     = key_match_reg;
        offset_next        = offset_reg;
        final_next         = final_reg;
        do_scan            = 1'b0;
        do_key             = 1'b0;
        result             = '0;

        if (start_flag)
        begin
            offset_next        = '0;
            brace_level_next   = DEPTH_BITS'(1);
            bracket_level_next = '0;
            escape_next        = 1'b0;
            key_index_next     = '0;
            key_match_next     = 1'b1;
            final_next         = jdkf_pkg::STATUS_SEARCH;
            if (data_byte == jdkf_pkg::CHAR_OBJ_OPEN)
            begin
                mode_next = jdkf_pkg::MODE_SCAN;
            end
            else
            begin
                mode_next  = jdkf_pkg::MODE_DONE;
                final_next = jdkf_pkg::STATUS_NOT_FOUND;
            end
        end
        else if (mode_reg != jdkf_pkg::MODE_IDLE && mode_reg != jdkf_pkg::MODE_DONE)
        begin
            if (offset_reg != '1)
            begin
                offset_next = offset_reg + OFFSET_BITS'(1);
            end
            case (mode_reg)
                jdkf_pkg::MODE_STR:
                begin
                    if (escape_reg)
                        escape_next = 1'b0;
                    else if (data_byte == jdkf_pkg::CHAR_BACKSLASH)
                        escape_next = 1'b1;
                    else if (data_byte == jdkf_pkg::CHAR_QUOTE)
                        mode_next = jdkf_pkg::MODE_SCAN;
                end
                jdkf_pkg::MODE_KEY:
                begin
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        do_key      = 1'b1;
                    end
                    else if (data_byte == jdkf_pkg::CHAR_BACKSLASH)
                    begin
                        escape_next = 1'b1;
                        do_key      = 1'b1;
                    end
                    else if (data_byte == jdkf_pkg::CHAR_QUOTE)
                    begin
                        key_match_next = key_match_reg && (key_index_reg == key_length);
                        mode_next      = jdkf_pkg::MODE_AFTER_KEY;
                    end
                    else
                    begin
                        do_key = 1'b1;
                    end
                end
                jdkf_pkg::MODE_AFTER_KEY:
                begin
                    if (!is_ws)
                    begin
                        if (data_byte == jdkf_pkg::CHAR_COLON)
                        begin
                            mode_next = key_match_reg ? jdkf_pkg::MODE_AFTER_COLON
                                                      : jdkf_pkg::MODE_SCAN;
                        end
                        else
                        begin
                            mode_next = jdkf_pkg::MODE_SCAN;
                            do_scan   = 1'b1;
                        end
                    end
                end
                jdkf_pkg::MODE_AFTER_COLON:
                begin
                    if (!is_ws)
                    begin
                        mode_next           = jdkf_pkg::MODE_DONE;
                        final_next          = jdkf_pkg::STATUS_FOUND;
                        result.value_offset = 16'(offset_next);
                        result.value_byte   = data_byte;
                    end
                end
                default:
                begin
                    do_scan = 1'b1;
                end
            endcase

            if (do_key && key_match_reg)
            begin
                if (key_index_reg >= key_length || key_index_reg >= KEY_LIMIT ||
                    key_index_reg[jdkf_pkg::KEY_LEN_BITS-1] || wanted != data_byte)
                    key_match_next = 1'b0;
                else
                    key_index_next = key_index_reg + jdkf_pkg::KEY_LEN_BITS'(1);
            end

            if (do_scan)
            begin
                case (data_byte)
                    jdkf_pkg::CHAR_QUOTE:
                    begin
                        escape_next = 1'b0;
                        if (brace_level_reg == DEPTH_BITS'(1) && bracket_level_reg == '0)
                        begin
                            mode_next      = jdkf_pkg::MODE_KEY;
                            key_index_next = '0;
                            key_match_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = jdkf_pkg::MODE_STR;
                        end
                    end
                    jdkf_pkg::CHAR_OBJ_OPEN:
                    begin
                        if (brace_level_reg == '1)
                        begin
                            mode_next  = jdkf_pkg::MODE_DONE;
                            final_next = jdkf_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            brace_level_next = brace_level_reg + DEPTH_BITS'(1);
                        end
                    end
                    jdkf_pkg::CHAR_OBJ_CLOSE:
                    begin
                        if (brace_level_reg <= DEPTH_BITS'(1))
                        begin
                            brace_level_next = '0;
                            mode_next        = jdkf_pkg::MODE_DONE;
                            final_next       = jdkf_pkg::STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            brace_level_next = brace_level_reg - DEPTH_BITS'(1);
                        end
                    end
                    jdkf_pkg::CHAR_ARR_OPEN:
                    begin
                        if (bracket_level_reg == '1)
                        begin
                            mode_next  = jdkf_pkg::MODE_DONE;
                            final_next = jdkf_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            bracket_level_next = bracket_level_reg + DEPTH_BITS'(1);
                        end
                    end
                    jdkf_pkg::CHAR_ARR_CLOSE:
                    begin
                        if (bracket_level_reg != '0)
                            bracket_level_next = bracket_level_reg - DEPTH_BITS'(1);
                    end
                    default: ;
                endcase
            end
        end

        if (start_flag ||
            (mode_reg != jdkf_pkg::MODE_IDLE && mode_reg != jdkf_pkg::MODE_DONE))
        begin
            if (end_flag && mode_next != jdkf_pkg::MODE_DONE)
            begin
                mode_next  = jdkf_pkg::MODE_DONE;
                final_next = jdkf_pkg::STATUS_NOT_FOUND;
            end
            result.status = (mode_next == jdkf_pkg::MODE_DONE) ? final_next
                                                               : jdkf_pkg::STATUS_SEARCH;
            if (result.status != jdkf_pkg::STATUS_FOUND)
            begin
                result.value_offset = '0;
                result.value_byte   = '0;
            end
        end
        else
        begin
            result.status = final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= jdkf_pkg::MODE_IDLE;
            brace_level_reg   <= '0;
            bracket_level_reg <= '0;
            escape_reg        <= 1'b0;
            key_index_reg     <= '0;
            key_match_reg     <= 1'b1;
            offset_reg        <= '0;
            final_reg         <= jdkf_pkg::STATUS_SEARCH;
        end
        else if (step_en)
        begin
            mode_reg          <= mode_next;
            brace_level_reg   <= brace_level_next;
            bracket_level_reg <= bracket_level_next;
            escape_reg        <= escape_next;
            key_index_reg     <= key_index_next;
            key_match_reg     <= key_match_next;
            offset_reg        <= offset_next;
            final_reg         <= final_next;
        end
    end

endmodule

// ===== design/json_direct_key_finder.sv =====
// Top level of the JSON direct key finder: input register, scan core, result register.
//
// The block takes JSON text one byte per word on the input channel (data_byte,
// start_flag, end_flag under in_valid and in_stall) and returns one result word
// per input word on the output channel (status, value_offset, value_byte under
// out_valid and out_stall). A word with start_flag set must carry the opening
// brace of the object to search and restarts the scan. The result of each byte
// reports searching, found (with the offset and first byte of the value), not
// found, or depth overflow; once the search has ended, later bytes repeat that
// status until the next start word.
// The user must load the wanted key through cfg_write, cfg_index and cfg_data
// while the block is idle; the block itself does not enforce this. An accepted
// word is held in the input register, and its result is registered in the
// result register when the scan core steps on it, which sets out_valid. One
// word can enter and one result leave every cycle while out_stall is low. When
// out_stall is high the result register holds, the input register keeps one
// waiting word, and in_stall rises only once both are full. Reset empties both
// registers, clears the scan state to idle and clears the key registers.
module json_direct_key_finder
#(
    parameter int DEPTH_BITS    = jdkf_pkg::DEPTH_BITS_DEFAULT,
    parameter int OFFSET_BITS   = jdkf_pkg::OFFSET_BITS_DEFAULT,
    parameter int MAX_KEY_BYTES = jdkf_pkg::MAX_KEY_BYTES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [jdkf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [jdkf_pkg::KEY_WORD_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                start_flag,
    input  logic                                end_flag,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [15:0]                         value_offset,
    output logic [7:0]                          value_byte
);

    logic [2*jdkf_pkg::KEY_WORD_BITS-1:0] key_bytes;
    logic [jdkf_pkg::KEY_LEN_BITS-1:0]    key_length;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       s1_end_reg;

    logic              out_valid_reg;
    jdkf_pkg::result_t out_result_reg;
    jdkf_pkg::result_t core_result;

    logic advance;
    logic step_en;
    logic load;

    assign advance  = !out_valid_reg || !out_stall;
    assign step_en  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    jdkf_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_bytes  (key_bytes),
        .key_length (key_length)
    );

    jdkf_scan_core
    #(
        .DEPTH_BITS    (DEPTH_BITS),
        .OFFSET_BITS   (OFFSET_BITS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    )
    u_scan_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .data_byte  (s1_byte_reg),
        .start_flag (s1_start_reg),
        .end_flag   (s1_end_reg),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= start_flag;
            s1_end_reg   <= end_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_result_reg.status;
    assign value_offset = out_result_reg.value_offset;
    assign value_byte   = out_result_reg.value_byte;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("Input stalled while a register stage is empty.");

    a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("A processed word did not reach the result register.");

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("Waiting input word was lost or changed.");

    a_value_only_when_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.status != jdkf_pkg::STATUS_FOUND) |->
        (out_result_reg.value_offset == '0 && out_result_reg.value_byte == '0))
        else $error("Value fields set without a found status.");

endmodule
